// ===== rtl/core/asfc_pkg.sv =====
`default_nettype none
package asfc_pkg;

    // Conversion mode codes
    localparam logic [2:0] MODE_U8_FLIP  = 3'd0;
    localparam logic [2:0] MODE_LE16     = 3'd1;
    localparam logic [2:0] MODE_BE16     = 3'd2;
    localparam logic [2:0] MODE_LE_FLOAT = 3'd3;
    localparam logic [2:0] MODE_BE_FLOAT = 3'd4;
    localparam logic [2:0] MODE_LE32     = 3'd5;
    localparam logic [2:0] MODE_BE32     = 3'd6;

    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

    // Saturation results of the float path, already in stream byte order
    localparam logic [31:0] SAT_POS_WORD = 32'hFFFF_FF7F;
    localparam logic [31:0] SAT_NEG_WORD = 32'h0000_0080;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
    } asfc_in_t;

    typedef struct packed {
        logic [31:0] result_word;
        logic [2:0]  result_bytes;
        logic        clipped;
    } asfc_out_t;

    typedef struct packed {
        logic [31:0] word;
        logic        clip;
    } float_res_t;

    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/asfc_float_conv.sv =====
`default_nettype none
module asfc_float_conv (
    input  wire logic [31:0]         float_bits,
    output asfc_pkg::float_res_t     res
);

    logic        sign;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic [54:0] prod;
    logic        rnd_up;
    logic [55:0] prod_rnd;
    logic [7:0]  sh_full;
    logic [62:0] scaled;
    logic [31:0] value;
    logic        sat_clip;

    assign sign = float_bits[31];
    assign expo = float_bits[30:23];
    assign mant = {(expo != 8'd0), float_bits[22:0]};

    // Multiply by 2^31-1 as shift and subtract
    assign prod = {mant, 31'b0} - {31'b0, mant};

    // Round the product to 53 significant bits, nearest even
    always_comb begin
        if (prod[54]) begin
            rnd_up   = prod[1] & (prod[0] | prod[2]);
            prod_rnd = {1'b0, prod[54:2], 2'b0} + {53'b0, rnd_up, 2'b0};
        end else begin
            rnd_up   = prod[0] & prod[1];
            prod_rnd = {1'b0, prod[54:1], 1'b0} + {54'b0, rnd_up, 1'b0};
        end
    end

    // Align to the integer point and truncate
    assign sh_full = 8'd157 - expo;
    assign scaled  = {prod_rnd, 7'b0} >> sh_full[5:0];

    // Saturate, handle NaN and infinity
    always_comb begin
        value    = 32'd0;
        sat_clip = 1'b0;
        if (expo == 8'hFF && float_bits[22:0] != 23'd0) begin
            sat_clip = 1'b1;
        end else if (expo >= 8'd158) begin
            sat_clip = 1'b1;
            value    = sign ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (expo < 8'd96) begin
            value = 32'd0;
        end else if (!sign) begin
            if (|scaled[62:31]) begin
                sat_clip = 1'b1;
                value    = 32'h7FFF_FFFF;
            end else begin
                value = {1'b0, scaled[30:0]};
            end
        end else begin
            if ((|scaled[62:32]) || (scaled[31] && (|scaled[30:0]))) begin
                sat_clip = 1'b1;
                value    = 32'h8000_0000;
            end else begin
                value = 32'd0 - scaled[31:0];
            end
        end
    end

    assign res = '{word: asfc_pkg::swap32(value), clip: sat_clip};

endmodule
`default_nettype wire

// ===== rtl/core/asfc_datapath.sv =====
`default_nettype none
module asfc_datapath (
    input  wire logic [2:0]          mode,
    input  wire asfc_pkg::asfc_in_t  item,
    output asfc_pkg::asfc_out_t      result
);

    logic [2:0]  count;
    logic [31:0] mask;
    logic [31:0] w;
    logic [31:0] float_in;
    logic        is_full;
    asfc_pkg::float_res_t fres;

    // Clamp the byte count and drop bytes beyond it
    assign count = (item.valid_bytes > asfc_pkg::FULL_WORD_BYTES) ?
                   asfc_pkg::FULL_WORD_BYTES : item.valid_bytes;
    assign mask  = {{8{count > 3'd3}}, {8{count > 3'd2}},
                    {8{count > 3'd1}}, {8{count > 3'd0}}};
    assign w       = item.data_word & mask;
    assign is_full = (count == asfc_pkg::FULL_WORD_BYTES);

    assign float_in = (mode == asfc_pkg::MODE_BE_FLOAT) ? asfc_pkg::swap32(w) : w;

    asfc_float_conv u_float (
        .float_bits (float_in),
        .res        (fres)
    );

    // Select the conversion
    always_comb begin
        result.result_word  = w;
        result.result_bytes = count;
        result.clipped      = 1'b0;
        case (mode)
            asfc_pkg::MODE_U8_FLIP: begin
                result.result_word = (w ^ 32'h8080_8080) & mask;
            end
            asfc_pkg::MODE_LE16: begin
                if (count >= 3'd2) begin
                    result.result_word[15:0] = {w[7:0], w[15:8]};
                end
                if (is_full) begin
                    result.result_word[31:16] = {w[23:16], w[31:24]};
                end
            end
            asfc_pkg::MODE_LE_FLOAT, asfc_pkg::MODE_BE_FLOAT: begin
                if (is_full) begin
                    result.result_word = fres.word;
                    result.clipped     = fres.clip;
                end
            end
            asfc_pkg::MODE_LE32: begin
                if (is_full) begin
                    result.result_word = asfc_pkg::swap32(w);
                end
            end
            default: begin
                result.result_word = w;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/audio_sample_format_converter_unit.sv =====
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_data    (data_word, valid_bytes)
// m_        m_valid / m_ready    m_data    (result_word, result_bytes, clipped)
// cfg_      cfg_wr_en            cfg_wr_data (conversion_mode)
//
// One word per cycle sustained while m_ready is high.
// The input register feeds the conversion logic, whose output lands in the
// result register; the float scaling path between them sets the clock limit.
// A stall on m_ready backs up through both registers; s_ready drops only once
// the input register is full and cannot advance.
// Synchronous active-low reset empties both registers and sets mode zero.
`default_nettype none
module audio_sample_format_converter_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire asfc_pkg::asfc_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output asfc_pkg::asfc_out_t      m_data,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_wr_data
);

    logic [2:0]           conv_mode_reg;
    logic                 in_valid_reg;
    asfc_pkg::asfc_in_t   in_data_reg;
    logic                 out_valid_reg;
    asfc_pkg::asfc_out_t  out_data_reg;
    asfc_pkg::asfc_out_t  conv_result;
    logic                 advance;

    // Move to the result register when it is empty or being drained
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;

    // Hold the conversion mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            conv_mode_reg <= asfc_pkg::MODE_U8_FLIP;
        end else if (cfg_wr_en) begin
            conv_mode_reg <= cfg_wr_data;
        end
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    asfc_datapath u_datapath (
        .mode   (conv_mode_reg),
        .item   (in_data_reg),
        .result (conv_result)
    );

    // Advance the converted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg <= conv_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_bytes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.result_bytes <= asfc_pkg::FULL_WORD_BYTES))
        else $error("result byte count above four");

    a_clip_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clipped) |->
        (conv_mode_reg == asfc_pkg::MODE_LE_FLOAT ||
         conv_mode_reg == asfc_pkg::MODE_BE_FLOAT))
        else $error("clip flag outside float modes");

    a_clip_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.clipped) |->
        (m_data.result_word == asfc_pkg::SAT_POS_WORD ||
         m_data.result_word == asfc_pkg::SAT_NEG_WORD ||
         m_data.result_word == 32'd0))
        else $error("clipped word is not a saturation code");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire
